// ===== rtl/cgemv_pkg.sv =====
// ----------------------------------------------------------------------------
// cgemv_pkg
// Shared types, constants and helpers for the complex GEMV accumulate core.
// ----------------------------------------------------------------------------
package cgemv_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = DATA_WIDTH - 1;
    localparam int ROW_WIDTH   = 6;
    localparam int NROWS_WIDTH = 7;
    localparam int NCOLS_WIDTH = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = 2 * DATA_WIDTH + 1;   // 16 x 17 signed product
    localparam int SUM_W       = PROD_W + 1;           // sum of two products

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_ACC_WIDTH = 48;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_IM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONJ_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONJ_X   = 3'd5;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] elem_re;
        logic signed [DATA_WIDTH-1:0] elem_im;
        logic signed [DATA_WIDTH-1:0] vec_re;
        logic signed [DATA_WIDTH-1:0] vec_im;
        logic signed [DATA_WIDTH-1:0] init_re;
        logic signed [DATA_WIDTH-1:0] init_im;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] out_re;
        logic signed [DATA_WIDTH-1:0] out_im;
        logic [ROW_WIDTH-1:0]         out_row;
        logic                         out_last;
    } out_item_t;

    typedef struct packed {
        logic [NROWS_WIDTH-1:0]       num_rows;
        logic [NCOLS_WIDTH-1:0]       num_cols;
        logic signed [DATA_WIDTH-1:0] alpha_re;
        logic signed [DATA_WIDTH-1:0] alpha_im;
        logic                         conj_a;
        logic                         conj_x;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XMUL,
        ST_XRND,
        ST_AMUL,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic x_mul;
        logic x_rnd;
        logic a_mul;
        logic acc;
        logic out_load;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic row_zero;
        logic last_col;
        logic out_busy;
    } status_t;

    // Round half up from Q.30 sum of products to Q1.15 with saturation.
    function automatic logic signed [DATA_WIDTH-1:0] round_sum(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [SUM_W:0]           t;
        logic signed [SUM_W-FRAC_BITS:0] r;
        t = (SUM_W + 1)'(s) + (SUM_W + 1)'(1 << (FRAC_BITS - 1));
        r = (SUM_W - FRAC_BITS + 1)'(t >>> FRAC_BITS);
        if (r > (SUM_W - FRAC_BITS + 1)'((1 << (DATA_WIDTH - 1)) - 1)) begin
            round_sum = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else if (r < -(SUM_W - FRAC_BITS + 1)'(1 << (DATA_WIDTH - 1))) begin
            round_sum = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            round_sum = DATA_WIDTH'(r);
        end
    endfunction

endpackage

// ===== rtl/cgemv_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgemv_ctrl
// Sequencer: steps one request through scale (on row zero), multiply, accumulate, output.
// ----------------------------------------------------------------------------
module cgemv_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cgemv_pkg::status_t status,
    output cgemv_pkg::cmd_t    cmd
);
    import cgemv_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.row_zero ? ST_XMUL : ST_AMUL;
                end
            end
            ST_XMUL: state_next = ST_XRND;
            ST_XRND: state_next = ST_AMUL;
            ST_AMUL: state_next = ST_ACC;
            ST_ACC:  state_next = ST_OUT;
            ST_OUT: begin
                // on the last column, hold while the previous result is still unread
                if (!(status.last_col && status.out_busy)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_XMUL: cmd.x_mul = 1'b1;
            ST_XRND: cmd.x_rnd = 1'b1;
            ST_AMUL: cmd.a_mul = 1'b1;
            ST_ACC:  cmd.acc   = 1'b1;
            ST_OUT: begin
                if (!(status.last_col && status.out_busy)) begin
                    cmd.advance  = 1'b1;
                    cmd.out_load = status.last_col;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== rtl/cgemv_datapath.sv =====
// ----------------------------------------------------------------------------
// cgemv_datapath
// Scaling multipliers, accumulator memory, row/column counters, output reg.
// ----------------------------------------------------------------------------
module cgemv_datapath #(
    parameter int MAX_ROWS  = cgemv_pkg::DEF_MAX_ROWS,
    parameter int ACC_WIDTH = cgemv_pkg::DEF_ACC_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cgemv_pkg::cmd_t      cmd,
    output cgemv_pkg::status_t   status,
    input  cgemv_pkg::cfg_t      cfg,
    input  cgemv_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cgemv_pkg::out_item_t m_data
);
    import cgemv_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = ((RW > NROWS_WIDTH) ? RW : NROWS_WIDTH) + 1;
    localparam int AW1 = ((ACC_WIDTH > SUM_W) ? ACC_WIDTH : SUM_W) + 1;
    localparam int RNW = ACC_WIDTH + 1;
    localparam int RSW = RNW - FRAC_BITS;

    localparam logic signed [AW1-1:0] ACC_HI =
        {{(AW1-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [AW1-1:0] ACC_LO = ~ACC_HI;
    localparam logic signed [RSW-1:0] DAT_HI =
        {{(RSW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [RSW-1:0] DAT_LO = ~DAT_HI;

    // item and counters
    in_item_t               item_reg;
    logic [RW-1:0]          row_count_reg, row_count_next;
    logic [NCOLS_WIDTH-1:0] col_count_reg, col_count_next;
    logic [CW-1:0]          m_eff;
    logic [NCOLS_WIDTH:0]   n_eff;
    logic                   last_row, last_col, col_zero;

    // scaling and products
    logic signed [DATA_WIDTH:0]   xr, xi, er, ei;
    logic signed [PROD_W-1:0]     xp0_reg, xp1_reg, xp2_reg, xp3_reg;
    logic signed [PROD_W-1:0]     ap0_reg, ap1_reg, ap2_reg, ap3_reg;
    logic signed [DATA_WIDTH-1:0] sx_re_reg, sx_im_reg;

    // accumulator
    logic signed [ACC_WIDTH-1:0] acc_mem_re [MAX_ROWS];
    logic signed [ACC_WIDTH-1:0] acc_mem_im [MAX_ROWS];
    logic signed [ACC_WIDTH-1:0] rd_re_reg, rd_im_reg;
    logic signed [ACC_WIDTH-1:0] new_re_reg, new_im_reg;
    logic signed [ACC_WIDTH-1:0] base_re, base_im, sat_re, sat_im;
    logic signed [AW1-1:0]       sum_re, sum_im;
    logic signed [SUM_W-1:0]     b_re, b_im;
    logic signed [DATA_WIDTH-1:0] o_re, o_im;

    // output
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;

    always_comb begin
        if (cfg.num_rows == '0) begin
            m_eff = CW'(1);
        end else if (CW'(cfg.num_rows) > CW'(MAX_ROWS)) begin
            m_eff = CW'(MAX_ROWS);
        end else begin
            m_eff = CW'(cfg.num_rows);
        end
        n_eff    = (cfg.num_cols == '0) ? (NCOLS_WIDTH+1)'(1)
                                        : (NCOLS_WIDTH+1)'(cfg.num_cols);
        last_row = (CW'(row_count_reg) + CW'(1)) >= m_eff;
        last_col = ((NCOLS_WIDTH+1)'(col_count_reg) + (NCOLS_WIDTH+1)'(1)) >= n_eff;
        col_zero = (col_count_reg == '0);
    end

    assign status.row_zero = (row_count_reg == '0);
    assign status.last_col = last_col;
    assign status.out_busy = m_valid_reg && !m_ready;

    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cmd.advance) begin
            if (last_row) begin
                row_count_next = '0;
                col_count_next = last_col ? '0 : col_count_reg + NCOLS_WIDTH'(1);
            end else begin
                row_count_next = row_count_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            sx_re_reg     <= '0;
            sx_im_reg     <= '0;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            if (cmd.x_rnd) begin
                sx_re_reg <= round_sum(SUM_W'(xp0_reg) - SUM_W'(xp1_reg));
                sx_im_reg <= round_sum(SUM_W'(xp2_reg) + SUM_W'(xp3_reg));
            end
        end
    end

    // conjugation widens by one bit so negating the most negative code is exact
    assign xr = (DATA_WIDTH+1)'(item_reg.vec_re);
    assign xi = cfg.conj_x ? -(DATA_WIDTH+1)'(item_reg.vec_im)
                           : (DATA_WIDTH+1)'(item_reg.vec_im);
    assign er = (DATA_WIDTH+1)'(item_reg.elem_re);
    assign ei = cfg.conj_a ? -(DATA_WIDTH+1)'(item_reg.elem_im)
                           : (DATA_WIDTH+1)'(item_reg.elem_im);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.x_mul) begin
            xp0_reg <= PROD_W'(cfg.alpha_re * xr);
            xp1_reg <= PROD_W'(cfg.alpha_im * xi);
            xp2_reg <= PROD_W'(cfg.alpha_re * xi);
            xp3_reg <= PROD_W'(cfg.alpha_im * xr);
        end
        if (cmd.a_mul) begin
            ap0_reg <= PROD_W'(er * sx_re_reg);
            ap1_reg <= PROD_W'(ei * sx_im_reg);
            ap2_reg <= PROD_W'(er * sx_im_reg);
            ap3_reg <= PROD_W'(ei * sx_re_reg);
        end
    end

    always_comb begin
        b_re    = SUM_W'(ap0_reg) - SUM_W'(ap1_reg);
        b_im    = SUM_W'(ap2_reg) + SUM_W'(ap3_reg);
        base_re = col_zero ? (ACC_WIDTH'(item_reg.init_re) <<< FRAC_BITS) : rd_re_reg;
        base_im = col_zero ? (ACC_WIDTH'(item_reg.init_im) <<< FRAC_BITS) : rd_im_reg;
        sum_re  = AW1'(base_re) + AW1'(b_re);
        sum_im  = AW1'(base_im) + AW1'(b_im);
        if (sum_re > ACC_HI) begin
            sat_re = ACC_HI[ACC_WIDTH-1:0];
        end else if (sum_re < ACC_LO) begin
            sat_re = ACC_LO[ACC_WIDTH-1:0];
        end else begin
            sat_re = sum_re[ACC_WIDTH-1:0];
        end
        if (sum_im > ACC_HI) begin
            sat_im = ACC_HI[ACC_WIDTH-1:0];
        end else if (sum_im < ACC_LO) begin
            sat_im = ACC_LO[ACC_WIDTH-1:0];
        end else begin
            sat_im = sum_im[ACC_WIDTH-1:0];
        end
    end

    // accumulator memory: registered read in the multiply step
    always_ff @(posedge aclk) begin
        if (cmd.a_mul) begin
            rd_re_reg <= acc_mem_re[row_count_reg];
            rd_im_reg <= acc_mem_im[row_count_reg];
        end
        if (cmd.acc) begin
            acc_mem_re[row_count_reg] <= sat_re;
            acc_mem_im[row_count_reg] <= sat_im;
            new_re_reg <= sat_re;
            new_im_reg <= sat_im;
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] round_acc(
        input logic signed [ACC_WIDTH-1:0] a
    );
        logic signed [RNW-1:0] t;
        logic signed [RSW-1:0] r;
        t = RNW'(a) + RNW'(1 << (FRAC_BITS - 1));
        r = RSW'(t >>> FRAC_BITS);
        if (r > DAT_HI) begin
            round_acc = DAT_HI[DATA_WIDTH-1:0];
        end else if (r < DAT_LO) begin
            round_acc = DAT_LO[DATA_WIDTH-1:0];
        end else begin
            round_acc = r[DATA_WIDTH-1:0];
        end
    endfunction

    assign o_re = round_acc(new_re_reg);
    assign o_im = round_acc(new_im_reg);

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.out_re   <= o_re;
            m_data_reg.out_im   <= o_im;
            m_data_reg.out_row  <= ROW_WIDTH'(row_count_reg);
            m_data_reg.out_last <= last_row;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/complex_gemv_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// complex_gemv_accumulate_core
// Complex y += alpha * op(A) * op(x) over a column-major matrix stream.
// ----------------------------------------------------------------------------
// One request carries one matrix element (row index fastest), the x value of
// its column and the initial y of its row. A request that opens a column (row
// zero) first runs the alpha*x multiply, then rounds it to Q1.15; each request
// then steps through multiply, accumulator memory read/update and output; on
// the last column the output step waits while an earlier result is still
// unread. Requests of the last column each return one result with
// the row's y rounded and saturated to Q1.15; out_last marks the final row.
// Registers may be written at any time but should only change between
// matrices; cfg_ready is always high.
module complex_gemv_accumulate_core #(
    parameter int MAX_ROWS  = cgemv_pkg::DEF_MAX_ROWS,
    parameter int ACC_WIDTH = cgemv_pkg::DEF_ACC_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  cgemv_pkg::in_item_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output cgemv_pkg::out_item_t             m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cgemv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cgemv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cgemv_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // configuration registers, reset to an identity-like setup
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_rows <= NROWS_WIDTH'(1);
            cfg_reg.num_cols <= NCOLS_WIDTH'(1);
            cfg_reg.alpha_re <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
            cfg_reg.alpha_im <= '0;
            cfg_reg.conj_a   <= 1'b0;
            cfg_reg.conj_x   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NUM_ROWS: cfg_reg.num_rows <= cfg_data[NROWS_WIDTH-1:0];
                REG_NUM_COLS: cfg_reg.num_cols <= cfg_data[NCOLS_WIDTH-1:0];
                REG_ALPHA_RE: cfg_reg.alpha_re <= cfg_data[DATA_WIDTH-1:0];
                REG_ALPHA_IM: cfg_reg.alpha_im <= cfg_data[DATA_WIDTH-1:0];
                REG_CONJ_A:   cfg_reg.conj_a   <= cfg_data[0];
                REG_CONJ_X:   cfg_reg.conj_x   <= cfg_data[0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    cgemv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cgemv_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
